FILE: rtl/core/tcw_pkg.sv
// Shared constants, codes and controller/datapath interface types for the text console writer.
package tcw_pkg;

	localparam int DEF_SCREEN_WIDTH  = 80;
	localparam int DEF_SCREEN_HEIGHT = 25;

	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 8;
	localparam int ATTR_W   = 8;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;
	localparam int OFFSET_W = 11;
	localparam int CELL_W   = 16;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_SET   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	localparam logic [CHAR_W-1:0] CH_NL = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0d;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

	// cursor update codes
	localparam logic [2:0] CUR_HOLD    = 3'd0;
	localparam logic [2:0] CUR_SETPOS  = 3'd1;
	localparam logic [2:0] CUR_HOME    = 3'd2;
	localparam logic [2:0] CUR_CR      = 3'd3;
	localparam logic [2:0] CUR_NEWLINE = 3'd4;
	localparam logic [2:0] CUR_ADVANCE = 3'd5;

	// memory write data select
	localparam logic [1:0] WR_BLANK = 2'd0;
	localparam logic [1:0] WR_CHAR  = 2'd1;
	localparam logic [1:0] WR_COPY  = 2'd2;

	typedef struct packed {
		logic       load;       // capture request fields
		logic [2:0] cur_op;
		logic       mul_pos;    // multiplier takes request position, not cursor
		logic       addr_ld;    // register multiplier result as cell address
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       rd_ctr;     // read at sweep counter + one row
		logic       ctr_clr;
		logic       ctr_inc;
		logic       scroll_set;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            is_nl;
		logic            is_cr;
		logic            row_last;
		logic            col_last;
		logic            copy_end;
		logic            sweep_end;
	} sts_t;

endpackage

FILE: rtl/core/tcw_datapath.sv
// Datapath: request registers, cursor, screen memory, sweep counter and result registers.
module tcw_datapath #(
	parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tcw_pkg::OP_W-1:0]        operation,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::POS_W-1:0]       position_row,
	input  logic [tcw_pkg::POS_W-1:0]       position_col,
	input  logic                            last_of_string,
	input  logic                            cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]      cfg_attr,
	input  tcw_pkg::cmd_t                   cmd,
	output tcw_pkg::sts_t                   sts,
	output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
	output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col,
	output logic [tcw_pkg::OFFSET_W-1:0]    cursor_offset,
	output logic                            cursor_commit,
	output logic                            scrolled,
	output logic [tcw_pkg::CHAR_W-1:0]      cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]      cell_attr
);
	import tcw_pkg::*;

	localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
	localparam int COL_W     = $clog2(SCREEN_WIDTH);
	localparam int PROD_W    = (ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W;
	localparam int CMP_W     = POS_W + 2;

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0]  pr_q;
	logic [POS_W-1:0]  pc_q;
	logic              last_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] ctr_q;
	logic              scroll_q;
	logic [CELL_W-1:0] rdata_q;
	logic [CELL_W-1:0] mem [CELLS];

	logic              in_range;
	logic [ROW_W-1:0]  mul_row;
	logic [COL_W-1:0]  mul_col;
	logic [PROD_W-1:0] prod;
	logic              row_last;
	logic              col_last;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;

	assign in_range = (CMP_W'(pr_q) < CMP_W'(SCREEN_HEIGHT)) &&
			(CMP_W'(pc_q) < CMP_W'(SCREEN_WIDTH));

	assign mul_row = cmd.mul_pos ? pr_q[ROW_W-1:0] : row_q;
	assign mul_col = cmd.mul_pos ? pc_q[COL_W-1:0] : col_q;
	assign prod    = PROD_W'(mul_row) * PROD_W'(SCREEN_WIDTH) + PROD_W'(mul_col);

	assign row_last = (row_q == ROW_W'(SCREEN_HEIGHT - 1));
	assign col_last = (col_q == COL_W'(SCREEN_WIDTH - 1));

	assign sts.op        = op_q;
	assign sts.is_nl     = (ch_q == CH_NL);
	assign sts.is_cr     = (ch_q == CH_CR);
	assign sts.row_last  = row_last;
	assign sts.col_last  = col_last;
	assign sts.copy_end  = (ctr_q == ADDR_W'(CELLS - SCREEN_WIDTH - 1));
	assign sts.sweep_end = (ctr_q == ADDR_W'(CELLS - 1));

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			ch_q   <= char_code;
			pr_q   <= position_row;
			pc_q   <= position_col;
			last_q <= last_of_string;
		end
		if (cmd.addr_ld) begin
			addr_q <= prod[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_attr;
		end
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else begin
			case (cmd.cur_op)
				CUR_SETPOS: begin
					if (in_range) begin
						row_q <= pr_q[ROW_W-1:0];
						col_q <= pc_q[COL_W-1:0];
					end else begin
						row_q <= '0;
						col_q <= '0;
					end
				end
				CUR_HOME: begin
					row_q <= '0;
					col_q <= '0;
				end
				CUR_CR: begin
					col_q <= '0;
				end
				CUR_NEWLINE: begin
					col_q <= '0;
					if (!row_last) row_q <= row_q + ROW_W'(1);
				end
				CUR_ADVANCE: begin
					if (col_last) begin
						col_q <= '0;
						if (!row_last) row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// sweep counter and scroll flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q    <= '0;
			scroll_q <= 1'b0;
		end else begin
			if (cmd.ctr_clr) begin
				ctr_q <= '0;
			end else if (cmd.ctr_inc) begin
				ctr_q <= ctr_q + ADDR_W'(1);
			end
			if (cmd.load) begin
				scroll_q <= 1'b0;
			end else if (cmd.scroll_set) begin
				scroll_q <= 1'b1;
			end
		end
	end

	// screen memory: one write port, one registered read port
	assign raddr = cmd.rd_ctr ? (ctr_q + ADDR_W'(SCREEN_WIDTH)) : addr_q;

	always_comb begin
		case (cmd.wr_sel)
			WR_CHAR: begin
				waddr = addr_q;
				wdata = {attr_q, ch_q};
			end
			WR_COPY: begin
				waddr = ctr_q;
				wdata = rdata_q;
			end
			default: begin
				waddr = ctr_q;
				wdata = BLANK_CELL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cursor_row    <= ROW_OUT_W'(row_q);
			cursor_col    <= COL_OUT_W'(col_q);
			cursor_offset <= prod[OFFSET_W-1:0];
			cursor_commit <= (op_q == OP_SET) || ((op_q == OP_WRITE) && last_q);
			scrolled      <= scroll_q;
			if ((op_q == OP_READ) && in_range) begin
				cell_char <= rdata_q[CHAR_W-1:0];
				cell_attr <= rdata_q[CELL_W-1:CHAR_W];
			end else begin
				cell_char <= '0;
				cell_attr <= '0;
			end
		end
	end

endmodule

FILE: rtl/core/tcw_ctrl.sv
// Controller: sequencer for request handling, memory sweeps and result handoff.
module tcw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  tcw_pkg::sts_t  sts,
	output tcw_pkg::cmd_t  cmd
);
	import tcw_pkg::*;

	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_EXEC    = 4'd2;
	localparam logic [3:0] S_WRITE   = 4'd3;
	localparam logic [3:0] S_READ    = 4'd4;
	localparam logic [3:0] S_COPY_RD = 4'd5;
	localparam logic [3:0] S_COPY_WR = 4'd6;
	localparam logic [3:0] S_BLANK   = 4'd7;
	localparam logic [3:0] S_FINISH  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_BLANK;
				cmd.ctr_inc = 1'b1;
				if (sts.sweep_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_WRITE: begin
						if (sts.is_nl) begin
							cmd.cur_op = CUR_NEWLINE;
							if (sts.row_last) begin
								cmd.scroll_set = 1'b1;
								cmd.ctr_clr    = 1'b1;
								state_d        = S_COPY_RD;
							end else begin
								state_d = S_FINISH;
							end
						end else if (sts.is_cr) begin
							cmd.cur_op = CUR_CR;
							state_d    = S_FINISH;
						end else begin
							cmd.addr_ld = 1'b1;
							state_d     = S_WRITE;
						end
					end
					OP_SET: begin
						cmd.cur_op = CUR_SETPOS;
						state_d    = S_FINISH;
					end
					OP_CLEAR: begin
						cmd.cur_op  = CUR_HOME;
						cmd.ctr_clr = 1'b1;
						state_d     = S_BLANK;
					end
					OP_READ: begin
						cmd.mul_pos = 1'b1;
						cmd.addr_ld = 1'b1;
						state_d     = S_READ;
					end
					default: begin
					end
				endcase
			end
			S_WRITE: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_CHAR;
				cmd.cur_op = CUR_ADVANCE;
				if (sts.col_last && sts.row_last) begin
					cmd.scroll_set = 1'b1;
					cmd.ctr_clr    = 1'b1;
					state_d        = S_COPY_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_COPY_RD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_COPY;
				cmd.ctr_inc = 1'b1;
				state_d     = sts.copy_end ? S_BLANK : S_COPY_RD;
			end
			S_BLANK: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_BLANK;
				cmd.ctr_inc = 1'b1;
				if (sts.sweep_end) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: controller, datapath and assertions.
// A character-cell console of SCREEN_WIDTH x SCREEN_HEIGHT cells (80 x 25 by default),
// each cell a character byte with an attribute byte above it, plus a cursor. Requests
// write a character, set the cursor, clear the screen or read one cell; each request
// gives exactly one result with the cursor afterward, its linear offset and, for a
// read, the cell contents. After reset the block sweeps the screen memory to blank
// (space, attribute 7), one cell a cycle, and in_stall stays high until the sweep is
// done. The block handles one request at a time through a small sequencer. An
// ordinary character, newline, carriage return, set cursor or read passes from
// acceptance to the result register through accept, decode/address multiply,
// memory access (character write or read only) and result load. Scrolling goes
// through the single memory port: each of the (SCREEN_HEIGHT-1)*SCREEN_WIDTH cells
// above the bottom row is read from the row below and then written back, after
// which the bottom row is blanked one cell a cycle, all through that one port.
// Clear screen is one blanking sweep of all cells. The result register sits between
// the two channels, so a new request may be accepted while a result still waits;
// the next result is loaded once the previous one has been taken. text_attribute is
// written through the cfg_valid/cfg_ready port, which is always ready, and should only
// be written while the block is idle; scrolling and clearing always blank with
// attribute 7 regardless of it.
module text_console_writer_unit #(
	parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tcw_pkg::OP_W-1:0]        operation,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::POS_W-1:0]       position_row,
	input  logic [tcw_pkg::POS_W-1:0]       position_col,
	input  logic                            last_of_string,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
	output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col,
	output logic [tcw_pkg::OFFSET_W-1:0]    cursor_offset,
	output logic                            cursor_commit,
	output logic                            scrolled,
	output logic [tcw_pkg::CHAR_W-1:0]      cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]      cell_attr,
	// attribute register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]      text_attribute
);
	import tcw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// attribute register accepts a write every cycle
	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.char_code      (char_code),
		.position_row   (position_row),
		.position_col   (position_col),
		.last_of_string (last_of_string),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_attr       (text_attribute),
		.cmd            (cmd),
		.sts            (sts),
		.cursor_row     (cursor_row),
		.cursor_col     (cursor_col),
		.cursor_offset  (cursor_offset),
		.cursor_commit  (cursor_commit),
		.scrolled       (scrolled),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr)
	);

	// one request in flight: after acceptance the request side is stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while previous one still in progress");

	// a scroll always leaves the cursor on the bottom row
	a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scrolled) |-> (cursor_row == ROW_OUT_W'(SCREEN_HEIGHT - 1)))
		else $error("scrolled result with cursor off the bottom row");

	// nonzero cell data only comes from a read, which neither commits nor scrolls
	a_cell_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (cell_char != '0 || cell_attr != '0)) |-> (!cursor_commit && !scrolled))
		else $error("cell data on a non-read result");

endmodule

FILE: sim/tb_text_console_writer_unit.sv
// Self-checking testbench for the text console writer: a directed table, then random phases.
module tb_text_console_writer_unit;
	import tcw_pkg::*;

	localparam int SCR_W = DEF_SCREEN_WIDTH;
	localparam int SCR_H = DEF_SCREEN_HEIGHT;
	localparam int CELLS = SCR_W * SCR_H;

	// Random phases, five attribute settings, about 106 requests each.
	localparam int PHASE_ITEMS = 106;

	// Scrolls and clears are long sweeps of the screen memory, so both are rationed
	// in the random part. Requests that would go over are turned into cheap ones.
	localparam int SCROLL_BUDGET = 50;
	localparam int CLEAR_BUDGET  = 20;

	// Watchdog. Slowest legal run: reset sweep, ~560 requests each seeing the
	// longest send gap, the longest result stall and its own work, the pressure
	// hold, ~55 scrolls and ~25 clears. The limit is about four times what that
	// run takes.
	localparam int CYCLE_LIMIT = 1_500_000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  prow;
		logic [POS_W-1:0]  pcol;
		logic              last;
	} request_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic [OFFSET_W-1:0]  offset;
		logic                 commit;
		logic                 scrolled;
		logic [CHAR_W-1:0]    cchar;
		logic [ATTR_W-1:0]    cattr;
	} cursor_report_t;

	logic clk;
	logic arst_n;

	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      operation;
	logic [CHAR_W-1:0]    char_code;
	logic [POS_W-1:0]     position_row;
	logic [POS_W-1:0]     position_col;
	logic                 last_of_string;

	logic                 out_valid;
	logic                 out_stall;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [COL_OUT_W-1:0] cursor_col;
	logic [OFFSET_W-1:0]  cursor_offset;
	logic                 cursor_commit;
	logic                 scrolled;
	logic [CHAR_W-1:0]    cell_char;
	logic [ATTR_W-1:0]    cell_attr;

	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [ATTR_W-1:0]    text_attribute;

	text_console_writer_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.char_code      (char_code),
		.position_row   (position_row),
		.position_col   (position_col),
		.last_of_string (last_of_string),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_row     (cursor_row),
		.cursor_col     (cursor_col),
		.cursor_offset  (cursor_offset),
		.cursor_commit  (cursor_commit),
		.scrolled       (scrolled),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.text_attribute (text_attribute)
	);

	// 10-unit clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow console: screen store, cursor and attribute as the block
	// should hold them after every accepted request.
	// ------------------------------------------------------------------
	logic [CELL_W-1:0] shadow_cells [CELLS];
	int                cur_row;
	int                cur_col;
	logic [ATTR_W-1:0] attr_setting;

	// Activity counts for the summary and for the scroll/clear rationing.
	int n_writes, n_reads, n_sets, n_clears, n_scrolls, n_attr_writes;

	// Expected results, oldest first.
	cursor_report_t awaited_reports [$];

	int fail_count;
	int reports_taken;
	int cycle_count;

	// Traffic shaping shared by sender and receiver.
	logic quiet;          // no idling on either side
	logic pressure_hold;  // receiver holds off for a long stretch
	int   stall_left;
	int   stall_roll;

	// Applies one request to the shadow console, returns the result it must give.
	function automatic cursor_report_t advance_console(request_t rq);
		cursor_report_t rp;
		int             idx;
		rp = '0;
		case (rq.op)
			OP_WRITE: begin
				n_writes++;
				if (rq.ch == CH_NL) begin
					cur_col = 0;
					cur_row++;
				end else if (rq.ch == CH_CR) begin
					cur_col = 0;
				end else begin
					idx = cur_row * SCR_W + cur_col;
					if (idx < CELLS)
						shadow_cells[idx] = {attr_setting, rq.ch};
					cur_col++;
				end
				// wrap off the last column
				if (cur_col >= SCR_W) begin
					cur_col = 0;
					cur_row++;
				end
				// off the bottom: shift up one row, blank the bottom row with
				// the fixed blank cell, not the configured attribute
				if (cur_row >= SCR_H) begin
					for (int i = 0; i < (SCR_H - 1) * SCR_W; i++)
						shadow_cells[i] = shadow_cells[i + SCR_W];
					for (int i = (SCR_H - 1) * SCR_W; i < CELLS; i++)
						shadow_cells[i] = BLANK_CELL;
					cur_row = SCR_H - 1;
					rp.scrolled = 1'b1;
					n_scrolls++;
				end
				rp.commit = rq.last;
			end
			OP_SET: begin
				n_sets++;
				// out of range on either axis homes the cursor
				if (rq.prow >= SCR_H || rq.pcol >= SCR_W) begin
					cur_row = 0;
					cur_col = 0;
				end else begin
					cur_row = rq.prow;
					cur_col = rq.pcol;
				end
				rp.commit = 1'b1;
			end
			OP_CLEAR: begin
				n_clears++;
				for (int i = 0; i < CELLS; i++)
					shadow_cells[i] = BLANK_CELL;
				cur_row = 0;
				cur_col = 0;
			end
			default: begin
				n_reads++;
				// out of range reads give zero and change nothing
				if (rq.prow < SCR_H && rq.pcol < SCR_W) begin
					idx = rq.prow * SCR_W + rq.pcol;
					rp.cchar = shadow_cells[idx][CHAR_W-1:0];
					rp.cattr = shadow_cells[idx][CELL_W-1:CHAR_W];
				end
			end
		endcase
		rp.row    = ROW_OUT_W'(cur_row);
		rp.col    = COL_OUT_W'(cur_col);
		rp.offset = OFFSET_W'(cur_row * SCR_W + cur_col);
		return rp;
	endfunction

	// Keeps the random part inside its cycle budget: a write that would scroll
	// becomes a cursor move off the bottom row, a clear becomes a read.
	function automatic request_t ration_request(request_t rq);
		request_t r;
		logic     would_scroll;
		r = rq;
		would_scroll = (r.op == OP_WRITE) && (cur_row == SCR_H - 1) &&
			(r.ch == CH_NL || (r.ch != CH_CR && cur_col == SCR_W - 1));
		if (would_scroll && n_scrolls >= SCROLL_BUDGET) begin
			r.op   = OP_SET;
			r.prow = POS_W'($urandom_range(0, SCR_H - 2));
			r.pcol = POS_W'($urandom_range(0, SCR_W - 1));
		end
		if (r.op == OP_CLEAR && n_clears >= CLEAR_BUDGET)
			r.op = OP_READ;
		return r;
	endfunction

	// Sender idle length: mostly none, some short, a few long.
	function automatic int send_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one request, waits for it to be taken, then records what it must
	// give: the typed value where one is given, else the shadow console's.
	task automatic offer_request(request_t rq, logic typed, cursor_report_t typed_rep);
		cursor_report_t rp;
		int             gap;
		in_valid       <= 1'b1;
		operation      <= rq.op;
		char_code      <= rq.ch;
		position_row   <= rq.prow;
		position_col   <= rq.pcol;
		last_of_string <= rq.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rp = advance_console(rq);
		awaited_reports.push_back(typed ? typed_rep : rp);
		gap = send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic offer_random(request_t rq);
		offer_request(ration_request(rq), 1'b0, '0);
	endtask

	// Drains the block, then writes the attribute register.
	task automatic write_attribute(logic [ATTR_W-1:0] value);
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid      <= 1'b1;
		text_attribute <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid    <= 1'b0;
		attr_setting = value;
		n_attr_writes++;
	endtask

	// One random phase: mostly cursor placement followed by a string, plus
	// reads, wild cursor sets, the odd clear and fully random noise.
	task automatic run_random_phase(int count);
		request_t rq;
		int       done;
		int       kind;
		int       len;
		int       r;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(0, 99);
			rq.op   = OP_WRITE;
			rq.ch   = CHAR_W'($urandom_range(0, 255));
			rq.prow = POS_W'($urandom_range(0, 255));
			rq.pcol = POS_W'($urandom_range(0, 255));
			rq.last = 1'b0;
			if (kind < 55) begin
				// place the cursor, often on the bottom row, then a string
				if ($urandom_range(0, 9) < 7) begin
					rq.op   = OP_SET;
					rq.prow = ($urandom_range(0, 4) == 0) ? POS_W'(SCR_H - 1) :
						POS_W'($urandom_range(0, SCR_H - 1));
					rq.pcol = POS_W'($urandom_range(0, SCR_W - 1));
					offer_random(rq);
					done++;
				end
				len = $urandom_range(1, 16);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					rq.op   = OP_WRITE;
					rq.ch   = (r < 10) ? CH_NL : (r < 15) ? CH_CR :
						CHAR_W'($urandom_range(0, 255));
					rq.prow = POS_W'($urandom_range(0, 255));
					rq.pcol = POS_W'($urandom_range(0, 255));
					rq.last = (k == len - 1);
					offer_random(rq);
				end
				done += len;
			end else if (kind < 80) begin
				rq.op = OP_READ;
				r = $urandom_range(0, 9);
				if (r < 6) begin
					rq.prow = POS_W'($urandom_range(0, SCR_H - 1));
					rq.pcol = POS_W'($urandom_range(0, SCR_W - 1));
				end else if (r < 8) begin
					// around the text just written
					rq.prow = POS_W'(cur_row);
					rq.pcol = POS_W'($urandom_range(0, SCR_W - 1));
				end
				offer_random(rq);
				done++;
			end else if (kind < 90) begin
				// full-range position, mostly out of range
				rq.op = OP_SET;
				offer_random(rq);
				done++;
			end else if (kind < 92) begin
				rq.op = OP_CLEAR;
				offer_random(rq);
				done++;
			end else begin
				rq.op   = OP_W'($urandom_range(0, 3));
				rq.last = 1'($urandom_range(0, 1));
				offer_random(rq);
				done++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Directed table. Typed rows carry a result that is plain from the
	// spec (reset contents, range limits, wrap and scroll at the corner,
	// clear); the others are checked against the shadow console.
	// ------------------------------------------------------------------
	request_t       dir_req   [$];
	logic           dir_typed [$];
	cursor_report_t dir_exp   [$];

	task automatic plan_row(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
			logic [POS_W-1:0] prow, logic [POS_W-1:0] pcol, logic last);
		dir_req.push_back({op, ch, prow, pcol, last});
		dir_typed.push_back(1'b0);
		dir_exp.push_back('0);
	endtask

	task automatic plan_typed(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
			logic [POS_W-1:0] prow, logic [POS_W-1:0] pcol, logic last,
			int erow, int ecol, int eoff, int ecommit, int escroll,
			logic [CHAR_W-1:0] echar, logic [ATTR_W-1:0] eattr);
		dir_req.push_back({op, ch, prow, pcol, last});
		dir_typed.push_back(1'b1);
		dir_exp.push_back({ROW_OUT_W'(erow), COL_OUT_W'(ecol), OFFSET_W'(eoff),
			1'(ecommit), 1'(escroll), echar, eattr});
	endtask

	initial begin
		//         op        ch     row    col    last  row col  off  cmt scr char   attr
		plan_typed(OP_READ,  8'h00, 8'd0,  8'd0,  1'b0, 0,  0,  0,   0,  0,  8'h20, 8'h07);
		plan_typed(OP_READ,  8'h00, 8'd24, 8'd79, 1'b0, 0,  0,  0,   0,  0,  8'h20, 8'h07);
		plan_typed(OP_READ,  8'h00, 8'd25, 8'd0,  1'b0, 0,  0,  0,   0,  0,  8'h00, 8'h00);
		plan_typed(OP_READ,  8'h00, 8'd0,  8'd80, 1'b0, 0,  0,  0,   0,  0,  8'h00, 8'h00);
		plan_typed(OP_READ,  8'hFF, 8'hFF, 8'hFF, 1'b1, 0,  0,  0,   0,  0,  8'h00, 8'h00);
		plan_typed(OP_SET,   8'h00, 8'hFF, 8'hFF, 1'b0, 0,  0,  0,   1,  0,  8'h00, 8'h00);
		plan_typed(OP_SET,   8'h00, 8'd24, 8'd79, 1'b0, 24, 79, 1999, 1, 0,  8'h00, 8'h00);
		// last cell: wraps and scrolls in one write
		plan_typed(OP_WRITE, 8'h41, 8'h00, 8'h00, 1'b1, 24, 0,  1920, 1, 1,  8'h00, 8'h00);
		plan_typed(OP_READ,  8'h00, 8'd23, 8'd79, 1'b0, 24, 0,  1920, 0, 0,  8'h41, 8'h07);
		plan_row  (OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		plan_row  (OP_WRITE, 8'h00, 8'h00, 8'h00, 1'b1);
		plan_row  (OP_WRITE, CH_NL, 8'h00, 8'h00, 1'b0);  // newline on bottom row
		plan_row  (OP_WRITE, CH_CR, 8'h00, 8'h00, 1'b1);
		plan_typed(OP_SET,   8'h00, 8'd12, 8'd40, 1'b0, 12, 40, 1000, 1, 0,  8'h00, 8'h00);
		plan_row  (OP_WRITE, CH_NL, 8'h00, 8'h00, 1'b1);
		plan_typed(OP_SET,   8'h00, 8'd0,  8'd79, 1'b0, 0,  79, 79,  1,  0,  8'h00, 8'h00);
		plan_row  (OP_WRITE, 8'h7A, 8'h00, 8'h00, 1'b0);  // wrap without scroll
		plan_row  (OP_READ,  8'h00, 8'd0,  8'd79, 1'b0);
		plan_row  (OP_READ,  8'h00, 8'd23, 8'd0,  1'b0);
		plan_row  (OP_READ,  8'h00, 8'd23, 8'd1,  1'b0);
		plan_typed(OP_CLEAR, 8'hAA, 8'h55, 8'hAA, 1'b1, 0,  0,  0,   0,  0,  8'h00, 8'h00);
		plan_typed(OP_READ,  8'h00, 8'd0,  8'd79, 1'b0, 0,  0,  0,   0,  0,  8'h20, 8'h07);
		plan_typed(OP_SET,   8'h00, 8'd24, 8'd80, 1'b0, 0,  0,  0,   1,  0,  8'h00, 8'h00);
		plan_typed(OP_SET,   8'h00, 8'd25, 8'd79, 1'b0, 0,  0,  0,   1,  0,  8'h00, 8'h00);
		plan_typed(OP_READ,  8'h00, 8'd24, 8'd79, 1'b0, 0,  0,  0,   0,  0,  8'h20, 8'h07);
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, the long hold-off, and the checks.
	// ------------------------------------------------------------------
	task automatic check_report(cursor_report_t got);
		cursor_report_t exp;
		if (awaited_reports.size() == 0) begin
			$error("result with nothing expected: row %0d col %0d", got.row, got.col);
			fail_count++;
			return;
		end
		exp = awaited_reports.pop_front();
		if (got.row !== exp.row) begin
			$error("cursor_row: expected %0d, actual %0d", exp.row, got.row);
			fail_count++;
		end
		if (got.col !== exp.col) begin
			$error("cursor_col: expected %0d, actual %0d", exp.col, got.col);
			fail_count++;
		end
		if (got.offset !== exp.offset) begin
			$error("cursor_offset: expected %0d, actual %0d", exp.offset, got.offset);
			fail_count++;
		end
		if (got.commit !== exp.commit) begin
			$error("cursor_commit: expected %0d, actual %0d", exp.commit, got.commit);
			fail_count++;
		end
		if (got.scrolled !== exp.scrolled) begin
			$error("scrolled: expected %0d, actual %0d", exp.scrolled, got.scrolled);
			fail_count++;
		end
		if (got.cchar !== exp.cchar) begin
			$error("cell_char: expected 0x%02h, actual 0x%02h", exp.cchar, got.cchar);
			fail_count++;
		end
		if (got.cattr !== exp.cattr) begin
			$error("cell_attr: expected 0x%02h, actual 0x%02h", exp.cattr, got.cattr);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			check_report({cursor_row, cursor_col, cursor_offset, cursor_commit,
				scrolled, cell_char, cell_attr});
			reports_taken++;
		end
		// next cycle's stall
		if (pressure_hold) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left = (stall_roll < 95) ? $urandom_range(0, 1) : $urandom_range(15, 60);
			end
		end
	end

	// Long hold-off partway through: the sender keeps offering, so the
	// result register and the request slot fill and in_stall must rise.
	initial begin
		pressure_hold <= 1'b0;
		wait (reports_taken >= 200);
		@(posedge clk);
		pressure_hold <= 1'b1;
		repeat (400) @(posedge clk);
		pressure_hold <= 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_reports.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		operation      <= OP_WRITE;
		char_code      <= '0;
		position_row   <= '0;
		position_col   <= '0;
		last_of_string <= 1'b0;
		out_stall      <= 1'b0;
		cfg_valid      <= 1'b0;
		text_attribute <= '0;
		quiet          <= 1'b0;
		stall_left    = 0;
		fail_count    = 0;
		reports_taken = 0;
		cycle_count   = 0;
		n_writes = 0; n_reads = 0; n_sets = 0; n_clears = 0; n_scrolls = 0;
		n_attr_writes = 0;

		// shadow console after reset
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = BLANK_CELL;
		cur_row      = 0;
		cur_col      = 0;
		attr_setting = ATTR_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset attribute; the block's blanking sweep
		// after reset simply holds off the first request.
		for (int i = 0; i < dir_req.size(); i++)
			offer_request(dir_req[i], dir_typed[i], dir_exp[i]);

		// Random phases, one per attribute setting; the middle one runs
		// without idling on either side.
		write_attribute(8'h00);
		run_random_phase(PHASE_ITEMS);
		write_attribute(8'hFF);
		run_random_phase(PHASE_ITEMS);
		write_attribute(ATTR_W'($urandom_range(1, 254)));
		quiet <= 1'b1;
		run_random_phase(PHASE_ITEMS);
		write_attribute(8'h8E);
		quiet <= 1'b0;
		run_random_phase(PHASE_ITEMS);
		write_attribute(ATTR_RESET);
		run_random_phase(PHASE_ITEMS);

		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (64) @(posedge clk);

		$display("covered %0d requests: %0d writes, %0d reads, %0d cursor sets, %0d clears",
			n_writes + n_reads + n_sets + n_clears, n_writes, n_reads, n_sets, n_clears);
		$display("  %0d scrolls, %0d attribute writes, %0d cycles, %0d mismatches",
			n_scrolls, n_attr_writes, cycle_count, fail_count);
		if (fail_count == 0 && awaited_reports.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer_unit.sv
sim/tb_text_console_writer_unit.sv
